@@ hdl/cte_pkg.sv @@
// cte_pkg: shared types, character constants and helper functions for the
// command line template expander
// no dependencies
package cte_pkg;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_UPPER_D = 8'h44;
    localparam logic [7:0] CH_UPPER_P = 8'h50;
    localparam logic [7:0] CH_UPPER_U = 8'h55;
    localparam logic [7:0] CH_LOWER_P = 8'h70;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_DASH    = 8'h2d;

    localparam logic [4:0] DEV_MAX      = 5'd25;
    localparam logic [6:0] PART_MAX     = 7'd99;
    localparam logic [6:0] PART_DEFAULT = 7'd3;

    localparam logic [5:0] GUID_LEN = 6'd36;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] CFG_DEVICE    = 3'd0;
    localparam logic [2:0] CFG_PARTITION = 3'd1;
    localparam logic [2:0] CFG_GUID_LOW  = 3'd2;
    localparam logic [2:0] CFG_GUID_HIGH = 3'd3;

    typedef enum logic [2:0] {
        OP_CHAR,
        OP_PCT,
        OP_PART,
        OP_DEV_DEC,
        OP_DEV_LET,
        OP_GUID
    } op_t;

    // one classified template step: a lead sequence chosen by op, then ch when tail is set
    typedef struct packed {
        op_t        op;
        logic [7:0] ch;
        logic       tail;
    } cmd_t;

    // tens digit of a value below 100
    function automatic logic [3:0] dec_tens(input logic [6:0] v);
        logic [3:0] t;
        t = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (v >= 7'(k * 10))
                t = 4'(k);
        end
        return t;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
            c = CH_ZERO + {4'd0, nib};
        else
            c = CH_LOWER_A + {4'd0, nib} - 8'd10;
        return c;
    endfunction

    // position in the canonical guid text -> {dash, nibble index into the 128-bit guid}
    function automatic logic [5:0] guid_map(input logic [5:0] pos);
        logic [5:0] q;
        logic [3:0] b;
        logic       dash;
        q    = 6'd0;
        b    = 4'd0;
        dash = 1'b0;
        if (pos < 6'd8)
        begin
            q = pos;
            b = 4'd3 - {1'b0, q[3:1]};
        end
        else if (pos >= 6'd9 && pos < 6'd13)
        begin
            q = pos - 6'd9;
            b = 4'd5 - {1'b0, q[3:1]};
        end
        else if (pos >= 6'd14 && pos < 6'd18)
        begin
            q = pos - 6'd14;
            b = 4'd7 - {1'b0, q[3:1]};
        end
        else if (pos >= 6'd19 && pos < 6'd23)
        begin
            q = pos - 6'd19;
            b = 4'd8 + {1'b0, q[3:1]};
        end
        else if (pos >= 6'd24)
        begin
            q = pos - 6'd24;
            b = 4'd10 + {1'b0, q[3:1]};
        end
        else
        begin
            dash = 1'b1;
        end
        // high nibble is printed first
        return {dash, b, ~q[0]};
    endfunction

endpackage

@@ hdl/cte_front.sv @@
// cte_front: accepts template bytes, tracks the escape state and classifies
// the bytes into commands for the back end
// depends on cte_pkg
module cte_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    in_char,
    input  logic          q_full,
    output logic          q_push,
    output cte_pkg::cmd_t q_cmd
);
    import cte_pkg::*;

    typedef enum logic [1:0] {
        MODE_PLAIN,
        MODE_PCT,
        MODE_DEV
    } mode_t;

    mode_t mode_reg;
    mode_t mode_next;
    logic  accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        mode_next  = mode_reg;
        q_push     = 1'b0;
        q_cmd.op   = OP_CHAR;
        q_cmd.ch   = in_char;
        q_cmd.tail = 1'b0;
        if (accept)
        begin
            case (mode_reg)
                MODE_PCT:
                begin
                    mode_next = MODE_PLAIN;
                    q_push    = 1'b1;
                    if (in_char == CH_NUL)
                        q_cmd.op = OP_CHAR;
                    else if (in_char == CH_UPPER_D)
                    begin
                        mode_next = MODE_DEV;
                        q_push    = 1'b0;
                    end
                    else if (in_char == CH_UPPER_P)
                        q_cmd.op = OP_PART;
                    else if (in_char == CH_UPPER_U)
                        q_cmd.op = OP_GUID;
                    else
                    begin
                        q_cmd.op   = OP_PCT;
                        q_cmd.tail = 1'b1;
                    end
                end
                MODE_DEV:
                begin
                    // lookahead byte picks digits or letter, then is copied plain, or opens an escape if a percent
                    q_push     = 1'b1;
                    q_cmd.op   = (in_char == CH_LOWER_P) ? OP_DEV_DEC : OP_DEV_LET;
                    q_cmd.tail = (in_char != CH_PERCENT);
                    mode_next  = (in_char == CH_PERCENT) ? MODE_PCT : MODE_PLAIN;
                end
                default:
                begin
                    if (in_char == CH_PERCENT)
                        mode_next = MODE_PCT;
                    else
                    begin
                        mode_next = MODE_PLAIN;
                        q_push    = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_PLAIN;
        else
            mode_reg <= mode_next;
    end

endmodule

@@ hdl/cte_queue.sv @@
// cte_queue: short command queue between the front and back ends
// depends on cte_pkg
module cte_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cte_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output cte_pkg::cmd_t head
);
    import cte_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

@@ hdl/cte_back.sv @@
// cte_back: steps through each queued command and emits one output byte per
// cycle into the output register unless stalled by out_stall
// depends on cte_pkg
module cte_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  cte_pkg::cmd_t head,
    output logic          q_pop,
    input  logic [4:0]    device_number,
    input  logic [6:0]    part_num,
    input  logic [127:0]  guid,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [7:0]    out_char,
    output logic          end_of_run
);
    import cte_pkg::*;

    logic [5:0] idx_reg;
    logic [5:0] idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_char_reg;
    logic       end_reg;

    logic       insane;
    logic [4:0] dev_eff;
    logic [6:0] part_eff;
    logic [6:0] dec_val;
    logic [3:0] tens;
    logic [6:0] ones_full;
    logic       two_digits;
    logic [5:0] gmap;
    logic [3:0] gnib;
    logic [5:0] lead_len;
    logic [7:0] lead_byte;
    logic [7:0] byte_now;
    logic       last;
    logic       advance;

    assign insane   = (device_number > DEV_MAX) || (part_num == 7'd0)
                   || (part_num > PART_MAX);
    assign dev_eff  = insane ? 5'd0 : device_number;
    assign part_eff = insane ? PART_DEFAULT : part_num;

    assign dec_val    = (head.op == OP_PART) ? part_eff : {2'b00, dev_eff};
    assign tens       = dec_tens(dec_val);
    assign ones_full  = dec_val - ({3'b000, tens} << 3) - ({3'b000, tens} << 1);
    assign two_digits = (dec_val > 7'd9);

    assign gmap = guid_map(idx_reg);
    assign gnib = guid[{gmap[4:0], 2'b00} +: 4];

    always_comb
    begin
        lead_len  = 6'd1;
        lead_byte = head.ch;
        case (head.op)
            OP_CHAR:
                lead_byte = head.ch;
            OP_PCT:
                lead_byte = CH_PERCENT;
            OP_PART, OP_DEV_DEC:
            begin
                lead_len = two_digits ? 6'd2 : 6'd1;
                if (two_digits && idx_reg == 6'd0)
                    lead_byte = CH_ZERO + {4'd0, tens};
                else
                    lead_byte = CH_ZERO + {4'd0, ones_full[3:0]};
            end
            OP_DEV_LET:
                lead_byte = CH_LOWER_A + {3'd0, dev_eff};
            OP_GUID:
            begin
                lead_len  = GUID_LEN;
                lead_byte = gmap[5] ? CH_DASH : hex_char(gnib);
            end
            default:
                lead_byte = head.ch;
        endcase
    end

    assign byte_now = (head.tail && idx_reg == lead_len) ? head.ch : lead_byte;
    assign last     = head.tail ? (idx_reg == lead_len) : (idx_reg == lead_len - 6'd1);
    assign advance  = q_valid && (!out_valid_reg || !out_stall);
    assign q_pop    = advance && last;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (advance)
        begin
            out_valid_next = 1'b1;
            idx_next       = last ? 6'd0 : idx_reg + 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_char_reg <= byte_now;
            end_reg      <= last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_char   = out_char_reg;
    assign end_of_run = end_reg;

`ifndef NO_ASSERTIONS
    // a guid run is the longest sequence
    assert property (@(posedge clk) disable iff (!rst_n) idx_reg < GUID_LEN)
        else $error("byte index past longest run");

    // a command part way through stays at the queue head
    assert property (@(posedge clk) disable iff (!rst_n) idx_reg != 6'd0 |-> q_valid)
        else $error("command left the queue mid-run");

    // a non-final step moves the index on by one
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && !last |=> idx_reg == $past(idx_reg) + 6'd1)
        else $error("byte index skipped");

    // each transfer loaded from a finished command is flagged as its last
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> out_valid && end_of_run)
        else $error("last byte not flagged");
`endif

endmodule

@@ hdl/cmdline_template_expander.sv @@
// cmdline_template_expander: top level with the register file, front end,
// command queue and back end
// depends on cte_pkg, cte_front, cte_queue, cte_back
//
// Usage: template bytes arrive on in_char under in_valid/in_stall, one byte
// per transfer, a zero byte closing each template. Expanded bytes leave on
// out_char under out_valid/out_stall; end_of_run marks the last byte that a
// given input byte produced. Settings are written through cfg_we, cfg_index
// and cfg_data while no template is in flight; indexes above 3 are ignored.
// An accepted input byte's command is written into the queue, and its first
// byte is then loaded from the queue head into the output register. The back
// end emits one byte per cycle while the receiver does not stall, so plain
// bytes sustain one per cycle; %P yields one or two digits, %D one or two
// digits after a p or else a letter, then the lookahead byte unless it is a
// percent, other escapes but NUL a percent and that byte, and %U 36 bytes.
// A four-entry command queue absorbs these runs; the input stalls only while
// it is full. When the receiver stalls, the output byte holds and the back
// end pauses. Reset returns the escape state to plain copying, empties the
// queue, clears the settings and sets the partition number to 3.
module cmdline_template_expander (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_char,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_char,
    output logic        end_of_run,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import cte_pkg::*;

    logic [4:0]  dev_reg;
    logic [6:0]  part_reg;
    logic [63:0] guid_low_reg;
    logic [63:0] guid_high_reg;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    cmd_t push_cmd;
    cmd_t head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_reg       <= 5'd0;
            part_reg      <= PART_DEFAULT;
            guid_low_reg  <= 64'd0;
            guid_high_reg <= 64'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEVICE:    dev_reg       <= cfg_data[4:0];
                CFG_PARTITION: part_reg      <= cfg_data[6:0];
                CFG_GUID_LOW:  guid_low_reg  <= cfg_data;
                CFG_GUID_HIGH: guid_high_reg <= cfg_data;
                default:       dev_reg       <= dev_reg;
            endcase
        end
    end

    cte_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_char  (in_char),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    cte_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (head)
    );

    cte_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .head          (head),
        .q_pop         (q_pop),
        .device_number (dev_reg),
        .part_num      (part_reg),
        .guid          ({guid_high_reg, guid_low_reg}),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_char      (out_char),
        .end_of_run    (end_of_run)
    );

endmodule
